// ===== sv/bpa_pkg.sv =====
package bpa_pkg;

  localparam int ADDR_W    = 64;
  localparam int CNT_W     = 18;
  localparam int SIZE_W    = 40;
  localparam int OP_W      = 3;
  localparam int REF_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_RETAIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd2;
  localparam logic [OP_W-1:0] OP_REL_RUN   = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd4;
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd5;

  localparam logic [REF_W-1:0] REF_LIMIT = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_PHYS_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGES = 1'b1;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_CLR,
    STEP_S1,
    STEP_S2,
    STEP_S3,
    STEP_S4,
    STEP_S5,
    STEP_RD,
    STEP_WR,
    STEP_ADDR,
    STEP_FILL
  } step_e;

  typedef struct packed {
    logic  load;
    step_e step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stop;
    logic loop_end;
    logic found;
    logic fill_last;
    logic out_busy;
    logic is_alloc;
    logic is_walk;
  } sts_t;

endpackage

// ===== sv/bpa_ctrl.sv =====
module bpa_ctrl import bpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_S1   = 4'd2;
  localparam logic [3:0] ST_S2   = 4'd3;
  localparam logic [3:0] ST_S3   = 4'd4;
  localparam logic [3:0] ST_S4   = 4'd5;
  localparam logic [3:0] ST_S5   = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_ADDR = 4'd9;
  localparam logic [3:0] ST_FILL = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '{load: 1'b0, step: STEP_NONE, emit: 1'b0};
    case (state_q)
      ST_CLR: begin
        cmd_o.step = STEP_CLR;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_S1;
      end
      ST_S1: begin
        cmd_o.step = STEP_S1;
        if (sts_i.stop) state_d = ST_DONE;
        else if (sts_i.is_alloc) state_d = ST_RD;
        else state_d = ST_S2;
      end
      ST_S2: begin
        cmd_o.step = STEP_S2;
        if (sts_i.stop) state_d = ST_DONE;
        else if (sts_i.is_walk) state_d = ST_S3;
        else state_d = ST_RD;
      end
      ST_S3: begin
        cmd_o.step = STEP_S3;
        state_d = sts_i.stop ? ST_DONE : ST_S4;
      end
      ST_S4: begin
        cmd_o.step = STEP_S4;
        state_d = sts_i.stop ? ST_DONE : ST_S5;
      end
      ST_S5: begin
        cmd_o.step = STEP_S5;
        state_d = sts_i.stop ? ST_DONE : ST_RD;
      end
      ST_RD: begin
        if (sts_i.loop_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = STEP_RD;
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        cmd_o.step = STEP_WR;
        state_d = sts_i.found ? ST_ADDR : ST_RD;
      end
      ST_ADDR: begin
        cmd_o.step = STEP_ADDR;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.step = STEP_FILL;
        if (sts_i.fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bpa_dp.sv =====
module bpa_dp import bpa_pkg::*; #(
  parameter int MAX_PAGES = 131072,
  parameter int PAGE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [CNT_W-1:0]     page_count_i,
  input  logic [SIZE_W-1:0]    byte_size_i,
  input  logic                 out_stall_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output logic                 status_o,
  output logic [ADDR_W-1:0]    result_address_o,
  output logic [CNT_W-1:0]     free_count_o
);

  localparam int AW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;
  localparam int HW = ADDR_W - PAGE_BITS;
  localparam int KW = HW + 1;
  localparam int NW = SIZE_W + 2;
  localparam int XW = (KW > NW) ? KW : NW;
  localparam int MW = REF_W + 1;
  localparam logic [ADDR_W-1:0] PG_SIZE = 64'd1 << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PG_MASK = PG_SIZE - 64'd1;
  localparam logic [LW-1:0]     LIM_MAX = LW'(MAX_PAGES);
  localparam logic [LW-1:0]     CLR_END = LW'(MAX_PAGES - 1);

  logic [MW-1:0] mem_q [MAX_PAGES];

  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  maxp_q;
  logic [LW-1:0]     free_q, page_q;
  logic              out_v_q;

  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q, diff_q, cur_q, res_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SIZE_W-1:0] size_q;
  logic              cy_q, ovf_q, status_q;
  logic [NW-1:0]     n_q, rem_q;
  logic [KW-1:0]     k0_q;
  logic [LW-1:0]     run_q;
  logic [MW-1:0]     rd_q;
  logic              out_status_q;
  logic [ADDR_W-1:0] out_res_q;
  logic [CNT_W-1:0]  out_free_q;

  logic [LW-1:0]     lim, run_inc;
  logic              is_alloc, is_walk, is_bad, aligned;
  logic [ADDR_W-1:0] a_w, add_x, add_y, s5_diff;
  logic [ADDR_W:0]   s1_sum, cur_next;
  logic [NW-1:0]     n_calc;
  logic [HW-1:0]     page_hi, s5_pg;
  logic              s2_page_ok, s5_ok, k0_ge_n;
  logic [KW-1:0]     k0_calc;
  logic [ADDR_W+1:0] a0_sum;
  logic              used;
  logic [REF_W-1:0]  refc;
  logic              found, wr_ok, inc_free, dec_free, stop;
  logic [MW-1:0]     wr_word, mem_wdata;
  logic              mem_we;

  assign lim      = (LW'(maxp_q) > LIM_MAX) ? LIM_MAX : LW'(maxp_q);
  assign is_alloc = (op_q == OP_ALLOC);
  assign is_walk  = (op_q == OP_MARK_FREE) || (op_q == OP_RESERVE);
  assign is_bad   = (op_q > OP_RESERVE);
  assign aligned  = (addr_q[PAGE_BITS-1:0] == '0);
  assign a_w      = (op_q == OP_RESERVE) ? (addr_q & ~PG_MASK) : addr_q;

  // walk ops: base + ~a, carry set when a is below base
  // page ops: addr - base, carry set when addr is at or above base
  assign add_x  = is_walk ? base_q : addr_q;
  assign add_y  = is_walk ? ~a_w : ~base_q;
  assign s1_sum = {1'b0, add_x} + {1'b0, add_y} + (ADDR_W+1)'(!is_walk);

  always_comb begin
    if (op_q == OP_RESERVE) begin
      if (size_q == '0) n_calc = '0;
      else n_calc = (NW'(addr_q[PAGE_BITS-1:0]) + NW'(size_q) + NW'(PG_MASK)) >> PAGE_BITS;
    end else begin
      n_calc = (NW'(size_q) + NW'(PG_MASK)) >> PAGE_BITS;
    end
  end

  assign page_hi    = diff_q[ADDR_W-1:PAGE_BITS];
  assign s2_page_ok = cy_q && aligned && (page_hi < HW'(lim));
  assign k0_calc    = cy_q ? ({1'b0, page_hi} + KW'(1)) : '0;
  assign k0_ge_n    = (XW'(k0_q) >= XW'(n_q));
  assign a0_sum     = {2'b00, a_w} + {1'b0, k0_q, {PAGE_BITS{1'b0}}};
  assign s5_diff    = cur_q - base_q;
  assign s5_pg      = s5_diff[ADDR_W-1:PAGE_BITS];
  assign s5_ok      = (s5_pg < HW'(lim));
  assign cur_next   = {1'b0, cur_q} + {1'b0, PG_SIZE};

  assign used    = rd_q[REF_W];
  assign refc    = rd_q[REF_W-1:0];
  assign run_inc = run_q + LW'(1);
  assign found   = is_alloc && !used && (run_inc == LW'(cnt_q));

  always_comb begin
    wr_word  = rd_q;
    wr_ok    = 1'b0;
    inc_free = 1'b0;
    dec_free = 1'b0;
    case (op_q)
      OP_RETAIN: begin
        if (refc != '0 && refc != REF_LIMIT) begin
          wr_word = {used, refc + REF_W'(1)};
          wr_ok   = 1'b1;
        end
      end
      OP_RELEASE, OP_REL_RUN: begin
        if (refc != '0) begin
          wr_ok = 1'b1;
          if (refc == REF_W'(1)) begin
            wr_word  = '0;
            inc_free = used;
          end else begin
            wr_word = {used, refc - REF_W'(1)};
          end
        end
      end
      OP_MARK_FREE: begin
        wr_word  = {1'b0, refc};
        inc_free = used;
      end
      OP_RESERVE: begin
        wr_word  = {1'b1, refc};
        dec_free = !used;
      end
      default: wr_word = rd_q;
    endcase
  end

  always_comb begin
    case (cmd_i.step)
      STEP_S1: stop = is_bad || (is_alloc && (cnt_q == '0 || LW'(cnt_q) > lim));
      STEP_S2: stop = is_walk ? (n_q == '0) : !s2_page_ok;
      STEP_S3: stop = k0_ge_n;
      STEP_S4: stop = |a0_sum[ADDR_W+1:ADDR_W];
      STEP_S5: stop = !s5_ok;
      default: stop = 1'b0;
    endcase
  end

  assign sts_o.clr_last  = (page_q == CLR_END);
  assign sts_o.stop      = stop;
  assign sts_o.loop_end  = (page_q >= lim) || (!is_alloc && (rem_q == '0 || ovf_q));
  assign sts_o.found     = found;
  assign sts_o.fill_last = (rem_q == NW'(1));
  assign sts_o.out_busy  = out_v_q && out_stall_i;
  assign sts_o.is_alloc  = is_alloc;
  assign sts_o.is_walk   = is_walk;

  assign mem_we = (cmd_i.step == STEP_CLR) || (cmd_i.step == STEP_FILL)
               || (cmd_i.step == STEP_WR && !is_alloc);

  always_comb begin
    case (cmd_i.step)
      STEP_CLR:  mem_wdata = {1'b1, {REF_W{1'b0}}};
      STEP_FILL: mem_wdata = {1'b1, REF_W'(1)};
      default:   mem_wdata = wr_word;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[page_q[AW-1:0]] <= mem_wdata;
    if (cmd_i.step == STEP_RD) rd_q <= mem_q[page_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      maxp_q  <= '0;
      free_q  <= '0;
      page_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PHYS_BASE: base_q <= cfg_data_i & ~PG_MASK;
          REG_MAX_PAGES: maxp_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.step)
        STEP_CLR: page_q <= sts_o.clr_last ? '0 : page_q + LW'(1);
        STEP_S1: begin
          if (is_alloc) page_q <= '0;
        end
        STEP_S2: begin
          if (!is_walk) page_q <= page_hi[LW-1:0];
        end
        STEP_S5: page_q <= s5_pg[LW-1:0];
        STEP_WR: begin
          page_q <= found ? (page_q + LW'(1) - LW'(cnt_q)) : (page_q + LW'(1));
          free_q <= free_q + LW'(inc_free) - LW'(dec_free);
        end
        STEP_FILL: begin
          page_q <= page_q + LW'(1);
          free_q <= free_q - LW'(1);
        end
        default: ;
      endcase
      if (cmd_i.emit) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      addr_q <= address_i;
      cnt_q  <= page_count_i;
      size_q <= byte_size_i;
      cur_q  <= address_i;
      ovf_q  <= 1'b0;
      res_q  <= '0;
    end
    case (cmd_i.step)
      STEP_S1: begin
        diff_q   <= s1_sum[ADDR_W-1:0];
        cy_q     <= s1_sum[ADDR_W];
        n_q      <= n_calc;
        status_q <= !is_walk;
        run_q    <= '0;
      end
      STEP_S2: begin
        k0_q <= k0_calc;
        if (!is_walk) begin
          rem_q <= (op_q == OP_REL_RUN) ? NW'(cnt_q) : NW'(1);
          if (op_q == OP_REL_RUN && s2_page_ok) status_q <= 1'b0;
        end
      end
      STEP_S3: rem_q <= n_q - k0_q[NW-1:0];
      STEP_S4: cur_q <= a0_sum[ADDR_W-1:0];
      STEP_WR: begin
        run_q <= used ? '0 : run_inc;
        rem_q <= rem_q - NW'(1);
        cur_q <= cur_next[ADDR_W-1:0];
        ovf_q <= ovf_q | cur_next[ADDR_W];
        if (wr_ok) status_q <= 1'b0;
      end
      STEP_ADDR: begin
        res_q    <= base_q + (ADDR_W'(page_q) << PAGE_BITS);
        rem_q    <= NW'(cnt_q);
        status_q <= 1'b0;
      end
      STEP_FILL: rem_q <= rem_q - NW'(1);
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_res_q    <= res_q;
      out_free_q   <= free_q[CNT_W-1:0];
    end
  end

  assign out_valid_o      = out_v_q;
  assign status_o         = out_status_q;
  assign result_address_o = out_res_q;
  assign free_count_o     = out_free_q;

endmodule

// ===== sv/bitmap_page_allocator_refcount.sv =====
// channel   direction  handshake               word
// in        input      in_valid_i / in_stall_o  opcode, address, page_count, byte_size
// out       output     out_valid_o / out_stall_i status, result_address, free_count
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// after reset a clearing pass over all MAX_PAGES pages sets every page used, count zero
// retain, release: steps S1 and S2, a read and a write of the page, then the output
// release run and ranges: setup steps (S1, S2, and S3 to S5 for ranges), a read and a write per page, then finish
// allocate: setup step S1, the RD and WR steps per page scanned from page zero, an address step,
//   a fill step per page of the run, then finish
// one word in flight; the next word is taken while the result waits in the output register
module bitmap_page_allocator_refcount import bpa_pkg::*; #(
  parameter int MAX_PAGES = 131072,
  parameter int PAGE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [CNT_W-1:0]     page_count_i,
  input  logic [SIZE_W-1:0]    byte_size_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic [ADDR_W-1:0]    result_address_o,
  output logic [CNT_W-1:0]     free_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bpa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .page_count_i     (page_count_i),
    .byte_size_i      (byte_size_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .result_address_o (result_address_o),
    .free_count_o     (free_count_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an operation is running");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.out_busy)
    else $error("result overwrites a stalled word");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid without a finished operation");

endmodule
